// File: rtl/core/skm_pkg.sv
// ----------------------------------------------------------------------------
// skm_pkg
// Shared types and constants for the sticky modifier key unit.
// ----------------------------------------------------------------------------
package skm_pkg;

	typedef logic [7:0] count_t;
	typedef logic [3:0] blink_t;
	typedef logic [2:0] mode_t;
	typedef logic [1:0] color_t;
	typedef logic [5:0] key_t;

	// modifier modes, one-shot codes are odd, locked codes follow them
	localparam mode_t MODE_NORMAL    = 3'd0;
	localparam mode_t MODE_SHIFT_ONE = 3'd1;
	localparam mode_t MODE_SHIFT_LCK = 3'd2;
	localparam mode_t MODE_SYM_ONE   = 3'd3;
	localparam mode_t MODE_SYM_LCK   = 3'd4;
	localparam mode_t MODE_FN_ONE    = 3'd5;
	localparam mode_t MODE_FN_LCK    = 3'd6;

	localparam int NUM_MOD = 3;

	// one-shot code per modifier, in priority order shift, sym, fn
	localparam mode_t MOD_ONE_SHOT [NUM_MOD] = '{MODE_SHIFT_ONE, MODE_SYM_ONE, MODE_FN_ONE};
	localparam mode_t MOD_LOCKED   [NUM_MOD] = '{MODE_SHIFT_LCK, MODE_SYM_LCK, MODE_FN_LCK};

	localparam color_t LED_OFF = 2'd0;

	localparam blink_t BLINK_ON_AT = 4'd4;
	localparam blink_t BLINK_TOP   = 4'd8;
	localparam key_t   KEY_NONE    = 6'd0;
	localparam key_t   KEY_MAX     = 6'd48;
	localparam count_t LONG_PRESS_RESET = 8'd10;

	typedef struct packed {
		logic shift_down;
		logic sym_down;
		logic fn_down;
		key_t key_index;
	} skm_in_t;

	typedef struct packed {
		logic   led_update;
		color_t led_color;
		logic   key_valid;
		key_t   key_out;
		mode_t  key_mode;
		mode_t  mode_now;
	} skm_out_t;

endpackage

// File: rtl/core/skm_if.sv
// ----------------------------------------------------------------------------
// skm_in_if / skm_out_if
// Valid/ready channels carrying scan words in and result words out.
// ----------------------------------------------------------------------------
interface skm_in_if;
	import skm_pkg::*;
	logic    valid;
	logic    ready;
	skm_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface skm_out_if;
	import skm_pkg::*;
	logic     valid;
	logic     ready;
	skm_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/sticky_modifier_key_fsm_unit.sv
// ----------------------------------------------------------------------------
// sticky_modifier_key_fsm_unit
// Sticky shift/sym/fn modifiers with long-press lock and blinking LED color.
// ----------------------------------------------------------------------------
// Usage:
//   scan   : one word per keyboard scan tick (modifier levels, key index).
//   result : one word per scan word (LED refresh and color, reported key,
//            lookup mode, mode held afterwards).
//   cfg_wr_en/cfg_wr_data : long-press limit, written while the unit is idle.
// Path: an accepted word waits in the input register; its result word is
//   then registered in the result register and held there until taken.
// Throughput: one word per cycle unless stalled; the mode, counter and blink
//   registers change in one short pass as a word leaves the input register.
// Stall: when result is not taken, the result register holds and the input
//   register takes one more word; scan.ready then drops until result moves.
// Reset: mode normal, all counters and blink cleared, limit 10, both
//   registers empty.
// ----------------------------------------------------------------------------
module sticky_modifier_key_fsm_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  skm_pkg::count_t cfg_wr_data,
	skm_in_if.sink          scan,
	skm_out_if.source       result
);
	import skm_pkg::*;

	logic     valid_s1;
	skm_in_t  word_s1;
	logic     out_valid_q;
	skm_out_t out_word_q;
	logic     advance;

	count_t   lim_q;
	mode_t    mode_q;
	count_t   cnt_q [NUM_MOD];
	blink_t   blink_q;

	mode_t    mode_n;
	count_t   cnt_n [NUM_MOD];
	blink_t   blink_n;
	skm_out_t res_n;

	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign scan.ready   = !valid_s1 || advance;
	assign result.valid = out_valid_q;
	assign result.data  = out_word_q;

	always_comb begin
		logic   early;
		logic   down [NUM_MOD];
		logic   kv;
		color_t c;
		early = 1'b0;
		kv    = 1'b0;
		c     = LED_OFF;
		down[0] = word_s1.shift_down;
		down[1] = word_s1.sym_down;
		down[2] = word_s1.fn_down;
		mode_n  = mode_q;
		blink_n = blink_q;
		for (int i = 0; i < NUM_MOD; i++) cnt_n[i] = cnt_q[i];
		res_n = '0;

		for (int i = 0; i < NUM_MOD; i++) begin
			if (!early) begin
				if (down[i]) begin
					if (mode_n != MODE_NORMAL) begin
						// pressing a modifier cancels the active mode
						cnt_n[i] = '0;
						mode_n   = MODE_NORMAL;
					end else begin
						if (cnt_n[i] < lim_q) cnt_n[i] = cnt_n[i] + 8'd1;
						for (int j = 0; j < NUM_MOD; j++) begin
							if (j != i) cnt_n[j] = '0;
						end
						blink_n = '0;
						early   = 1'b1;
					end
				end
				if (!early) begin
					if (cnt_n[i] == lim_q) mode_n = MOD_LOCKED[i];
					else if (cnt_n[i] != '0) mode_n = MOD_ONE_SHOT[i];
				end
			end
		end

		if (!early) begin
			if (mode_n != MODE_NORMAL) begin
				c = color_t'((4'(mode_n) + 4'd1) >> 1);
				if (mode_n[0] && blink_n < BLINK_ON_AT) c = LED_OFF;
			end
			res_n.led_update = 1'b1;
			res_n.led_color  = c;
			kv = (word_s1.key_index != KEY_NONE) && (word_s1.key_index <= KEY_MAX);
			if (kv) begin
				res_n.key_valid = 1'b1;
				res_n.key_out   = word_s1.key_index;
				res_n.key_mode  = mode_n;
				// a key consumes a one-shot mode
				if (mode_n[0]) begin
					mode_n = MODE_NORMAL;
					for (int i = 0; i < NUM_MOD; i++) cnt_n[i] = '0;
				end
			end
			if (blink_n < BLINK_TOP) blink_n = blink_n + 4'd1;
			else blink_n = '0;
		end
		res_n.mode_now = mode_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			lim_q       <= LONG_PRESS_RESET;
			mode_q      <= MODE_NORMAL;
			blink_q     <= '0;
			for (int i = 0; i < NUM_MOD; i++) cnt_q[i] <= '0;
		end else begin
			if (cfg_wr_en) lim_q <= cfg_wr_data;
			if (scan.ready) valid_s1 <= scan.valid;
			if (advance) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
			if (advance) begin
				mode_q  <= mode_n;
				blink_q <= blink_n;
				for (int i = 0; i < NUM_MOD; i++) cnt_q[i] <= cnt_n[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan.ready && scan.valid) word_s1 <= scan.data;
		if (advance) out_word_q <= res_n;
	end

endmodule

// File: rtl/core/skm_checker.sv
// ----------------------------------------------------------------------------
// skm_checker
// Port-level checks on the result channel of the sticky modifier unit.
// ----------------------------------------------------------------------------
module skm_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input skm_pkg::skm_out_t out_data
);
	import skm_pkg::*;

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed under stall");

	// no key reported on a word without LED refresh (modifier held)
	a_held_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.led_update |->
			!out_data.key_valid && out_data.led_color == LED_OFF)
		else $error("modifier-held word carries a key or color");

	a_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.key_valid |->
			out_data.key_out == KEY_NONE && out_data.key_mode == MODE_NORMAL)
		else $error("key fields set without a key");

	// a key in one-shot mode returns to normal
	a_one_shot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.key_valid && out_data.key_mode[0] |->
			out_data.mode_now == MODE_NORMAL)
		else $error("one-shot mode survived a key");

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.mode_now <= MODE_FN_LCK && out_data.key_mode <= MODE_FN_LCK)
		else $error("mode code out of range");

endmodule

bind sticky_modifier_key_fsm_unit skm_checker u_skm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);
